[hw/rtl/af3_pkg.sv]
// shared types, widths and reset values of the three-axis admittance filter
`default_nettype none

package af3_pkg;

  localparam int AXES    = 3;
  localparam int FORCE_W = 20;   // sample and bias, Q11.8
  localparam int NET_F_W = 21;   // bias minus sample, no loss
  localparam int STATE_W = 32;   // velocity and offset, Q.24
  localparam int GAIN_W  = 24;
  localparam int DT_W    = 32;
  localparam int LIM_W   = 31;
  localparam int DB_W    = 19;
  localparam int MUL_W   = 33;   // signed operand width of the lane multiplier
  localparam int PROD_W  = 66;
  localparam int ACC_W   = 81;
  localparam int N16_W   = 40;
  localparam int ACCEL_W = 48;
  localparam int SQ_W    = 40;
  localparam int SQSUM_W = 42;
  localparam int DBSQ_W  = 38;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0] INV_MASS_RST  = 24'd8192;
  localparam logic [GAIN_W-1:0] DAMPING_RST   = 24'd20480;
  localparam logic [GAIN_W-1:0] STIFFNESS_RST = 24'd0;
  localparam logic [DT_W-1:0]   TIMESTEP_RST  = 32'd8589935;
  localparam logic [DB_W-1:0]   DEADBAND_RST  = 19'd640;
  localparam logic [LIM_W-1:0]  MAX_VEL_RST   = 31'd4194304;
  localparam logic [LIM_W-1:0]  MAX_OFS_RST   = 31'd3355443;

  typedef enum logic [1:0] {
    CMD_MEASURED = 2'd0,
    CMD_TARE     = 2'd1,
    CMD_DIRECT   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_MASS  = 3'd0,
    CFG_DAMPING   = 3'd1,
    CFG_STIFFNESS = 3'd2,
    CFG_TIMESTEP  = 3'd3,
    CFG_DEADBAND  = 3'd4,
    CFG_MAX_VEL   = 3'd5,
    CFG_MAX_OFS   = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQR, ST_SUM, ST_CHK,
    ST_DV, ST_KX, ST_NET, ST_N16,
    ST_MH, ST_ML, ST_AS, ST_ACC,
    ST_TH, ST_TL, ST_TS, ST_V,
    ST_XM, ST_XA, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_SQR, OP_SUM, OP_CLR,
    OP_DV, OP_KX, OP_NET, OP_N16,
    OP_MH, OP_ML, OP_AS, OP_ACC,
    OP_TH, OP_TL, OP_TS, OP_V,
    OP_XM, OP_XA
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     load;
    logic     tare;
    logic     measured;
  } lane_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/admittance_filter_3axis.sv]
// top level of the three-axis admittance filter: config registers, lanes and result register
`default_nettype none

// Three-axis admittance filter. Each request carries a force sample and a command:
// measured (bias minus sample, zeroed under the deadband), tare (latch the bias) or
// direct. A nonzero force advances a mass-spring-damper one explicit Euler step per
// axis, with velocity and offset saturated per component; a zero force clears the
// velocity and holds the offset. One result comes back for every request. Three axis
// lanes run in lockstep, each with one 33x33 multiplier that is shared over the squared
// force and seven products of the update. A request that moves the state runs through
// every sequencer state, a zero-force one only square, sum and check, a tare or unused
// command straight to output; no new request is taken until the result register loads.
// Configuration is taken on any cycle with cfg_we high; writes beyond the register list
// are ignored. Offsets and velocities are Q.24, forces Q11.8 newtons.

module admittance_filter_3axis (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     cfg_we,
  input  wire logic        [af3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic        [af3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic        [1:0]                        in_command,
  input  wire logic signed [af3_pkg::FORCE_W-1:0]       in_force_x,
  input  wire logic signed [af3_pkg::FORCE_W-1:0]       in_force_y,
  input  wire logic signed [af3_pkg::FORCE_W-1:0]       in_force_z,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed      [af3_pkg::STATE_W-1:0]       out_offset_x,
  output logic signed      [af3_pkg::STATE_W-1:0]       out_offset_y,
  output logic signed      [af3_pkg::STATE_W-1:0]       out_offset_z,
  output logic signed      [af3_pkg::STATE_W-1:0]       out_velocity_x,
  output logic signed      [af3_pkg::STATE_W-1:0]       out_velocity_y,
  output logic signed      [af3_pkg::STATE_W-1:0]       out_velocity_z,
  output logic                                          out_force_admitted
);

  // configuration registers
  logic [af3_pkg::GAIN_W-1:0] inv_mass_r;
  logic [af3_pkg::GAIN_W-1:0] damping_r;
  logic [af3_pkg::GAIN_W-1:0] stiffness_r;
  logic [af3_pkg::DT_W-1:0]   timestep_r;
  logic [af3_pkg::DB_W-1:0]   deadband_r;
  logic [af3_pkg::LIM_W-1:0]  max_vel_r;
  logic [af3_pkg::LIM_W-1:0]  max_ofs_r;

  // sequencer and lane wiring
  af3_pkg::lane_ctl_t                              ctl;
  logic                                            admitted;
  logic                                            out_free;
  logic                                            out_load;
  logic signed [af3_pkg::FORCE_W-1:0]              lane_force [af3_pkg::AXES];
  logic [af3_pkg::AXES-1:0][af3_pkg::SQ_W-1:0]     lane_sq;
  logic [af3_pkg::AXES-1:0]                        lane_nz;
  logic signed [af3_pkg::STATE_W-1:0]              lane_vel [af3_pkg::AXES];
  logic signed [af3_pkg::STATE_W-1:0]              lane_ofs [af3_pkg::AXES];

  // result register
  logic                                            out_valid_r;
  logic signed [af3_pkg::STATE_W-1:0]              out_vel_r [af3_pkg::AXES];
  logic signed [af3_pkg::STATE_W-1:0]              out_ofs_r [af3_pkg::AXES];
  logic                                            out_adm_r;

  // register writes, indexes past the list fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r  <= af3_pkg::INV_MASS_RST;
      damping_r   <= af3_pkg::DAMPING_RST;
      stiffness_r <= af3_pkg::STIFFNESS_RST;
      timestep_r  <= af3_pkg::TIMESTEP_RST;
      deadband_r  <= af3_pkg::DEADBAND_RST;
      max_vel_r   <= af3_pkg::MAX_VEL_RST;
      max_ofs_r   <= af3_pkg::MAX_OFS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        af3_pkg::CFG_INV_MASS:  inv_mass_r  <= cfg_wdata[af3_pkg::GAIN_W-1:0];
        af3_pkg::CFG_DAMPING:   damping_r   <= cfg_wdata[af3_pkg::GAIN_W-1:0];
        af3_pkg::CFG_STIFFNESS: stiffness_r <= cfg_wdata[af3_pkg::GAIN_W-1:0];
        af3_pkg::CFG_TIMESTEP:  timestep_r  <= cfg_wdata[af3_pkg::DT_W-1:0];
        af3_pkg::CFG_DEADBAND:  deadband_r  <= cfg_wdata[af3_pkg::DB_W-1:0];
        af3_pkg::CFG_MAX_VEL:   max_vel_r   <= cfg_wdata[af3_pkg::LIM_W-1:0];
        af3_pkg::CFG_MAX_OFS:   max_ofs_r   <= cfg_wdata[af3_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // the next result may load once the current one is taken or in the same cycle
  assign out_free = !out_valid_r || out_ready;

  af3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .admitted   (admitted),
    .out_free   (out_free),
    .in_ready   (in_ready),
    .ctl        (ctl),
    .out_load   (out_load)
  );

  assign lane_force[0] = in_force_x;
  assign lane_force[1] = in_force_y;
  assign lane_force[2] = in_force_z;

  // one lane per axis, all driven by the same step
  for (genvar g = 0; g < af3_pkg::AXES; g++) begin : g_lane
    af3_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .force_in     (lane_force[g]),
      .damping      (damping_r),
      .stiffness    (stiffness_r),
      .inverse_mass (inv_mass_r),
      .timestep     (timestep_r),
      .max_velocity (max_vel_r),
      .max_offset   (max_ofs_r),
      .force_sq     (lane_sq[g]),
      .force_nz     (lane_nz[g]),
      .velocity     (lane_vel[g]),
      .offset       (lane_ofs[g])
    );
  end

  // deadband on the squared norm and the zero-force check across lanes
  af3_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .force_sq       (lane_sq),
    .force_nz       (lane_nz),
    .force_deadband (deadband_r),
    .admitted       (admitted)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // snapshot of the state after the step
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < af3_pkg::AXES; i++) begin
        out_vel_r[i] <= lane_vel[i];
        out_ofs_r[i] <= lane_ofs[i];
      end
      out_adm_r <= admitted;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_offset_x       = out_ofs_r[0];
  assign out_offset_y       = out_ofs_r[1];
  assign out_offset_z       = out_ofs_r[2];
  assign out_velocity_x     = out_vel_r[0];
  assign out_velocity_y     = out_vel_r[1];
  assign out_velocity_z     = out_vel_r[2];
  assign out_force_admitted = out_adm_r;

endmodule

`default_nettype wire

[hw/rtl/af3_lane.sv]
// one axis of the filter: bias, state and a shared multiplier stepped by the sequencer
`default_nettype none

module af3_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire af3_pkg::lane_ctl_t                    ctl,
  input  wire logic signed [af3_pkg::FORCE_W-1:0]    force_in,
  input  wire logic        [af3_pkg::GAIN_W-1:0]     damping,
  input  wire logic        [af3_pkg::GAIN_W-1:0]     stiffness,
  input  wire logic        [af3_pkg::GAIN_W-1:0]     inverse_mass,
  input  wire logic        [af3_pkg::DT_W-1:0]       timestep,
  input  wire logic        [af3_pkg::LIM_W-1:0]      max_velocity,
  input  wire logic        [af3_pkg::LIM_W-1:0]      max_offset,
  output logic             [af3_pkg::SQ_W-1:0]       force_sq,
  output logic                                       force_nz,
  output logic signed      [af3_pkg::STATE_W-1:0]    velocity,
  output logic signed      [af3_pkg::STATE_W-1:0]    offset
);

  logic signed [af3_pkg::FORCE_W-1:0] bias_r;
  logic signed [af3_pkg::FORCE_W-1:0] samp_r;
  logic signed [af3_pkg::NET_F_W-1:0] frc_r;
  logic signed [af3_pkg::NET_F_W-1:0] frc_c;
  logic signed [af3_pkg::STATE_W-1:0] vel_r;
  logic signed [af3_pkg::STATE_W-1:0] vel_nxt;
  logic signed [af3_pkg::STATE_W-1:0] ofs_r;
  logic signed [af3_pkg::STATE_W-1:0] ofs_nxt;
  logic signed [af3_pkg::MUL_W-1:0]   mul_a;
  logic signed [af3_pkg::MUL_W-1:0]   mul_b;
  logic signed [af3_pkg::PROD_W-1:0]  prod_c;
  logic signed [af3_pkg::PROD_W-1:0]  prod_r;
  logic signed [af3_pkg::ACC_W-1:0]   prod_ext;
  logic signed [af3_pkg::ACC_W-1:0]   net_base;
  logic signed [af3_pkg::ACC_W-1:0]   acc_r;
  logic signed [af3_pkg::ACC_W-1:0]   n_sh;
  logic signed [af3_pkg::ACC_W-1:0]   a_sh;
  logic signed [af3_pkg::ACC_W-1:0]   t_sh;
  logic signed [af3_pkg::N16_W-1:0]   n16_r;
  logic signed [af3_pkg::N16_W-1:0]   n16_nxt;
  logic signed [af3_pkg::ACCEL_W-1:0] accel_r;
  logic signed [af3_pkg::ACCEL_W-1:0] accel_nxt;
  logic signed [49:0]                 vsum;
  logic signed [49:0]                 vlim;
  logic signed [af3_pkg::PROD_W-1:0]  x_sh;
  logic signed [35:0]                 xsum;
  logic signed [35:0]                 xlim;

  // measured force is bias minus sample, direct force is the sample
  assign frc_c = ctl.measured ? ({bias_r[19], bias_r} - {samp_r[19], samp_r})
                              : {samp_r[19], samp_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.op)
      af3_pkg::OP_SQR: begin
        mul_a = {{12{frc_c[20]}}, frc_c};
        mul_b = {{12{frc_c[20]}}, frc_c};
      end
      af3_pkg::OP_DV: begin
        mul_a = {9'd0, damping};
        mul_b = {vel_r[31], vel_r};
      end
      af3_pkg::OP_KX: begin
        mul_a = {9'd0, stiffness};
        mul_b = {ofs_r[31], ofs_r};
      end
      af3_pkg::OP_MH: begin
        mul_a = {{9{n16_r[39]}}, n16_r[39:16]};
        mul_b = {9'd0, inverse_mass};
      end
      af3_pkg::OP_ML: begin
        mul_a = {17'd0, n16_r[15:0]};
        mul_b = {9'd0, inverse_mass};
      end
      af3_pkg::OP_TH: begin
        mul_a = {{9{accel_r[47]}}, accel_r[47:24]};
        mul_b = {1'b0, timestep};
      end
      af3_pkg::OP_TL: begin
        mul_a = {9'd0, accel_r[23:0]};
        mul_b = {1'b0, timestep};
      end
      af3_pkg::OP_XM: begin
        mul_a = {vel_r[31], vel_r};
        mul_b = {1'b0, timestep};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c   = $signed({{af3_pkg::MUL_W{mul_a[af3_pkg::MUL_W-1]}}, mul_a})
                  * $signed({{af3_pkg::MUL_W{mul_b[af3_pkg::MUL_W-1]}}, mul_b});
  assign prod_ext = {{15{prod_r[65]}}, prod_r};
  assign net_base = {{36{frc_r[20]}}, frc_r, 24'd0};

  // net force down to 16 fraction bits, saturated to 40 bits
  always_comb begin
    n_sh = acc_r >>> 16;
    if (!n_sh[80] && (|n_sh[79:39])) begin
      n16_nxt = {1'b0, {39{1'b1}}};
    end else if (n_sh[80] && !(&n_sh[79:39])) begin
      n16_nxt = {1'b1, {39{1'b0}}};
    end else begin
      n16_nxt = n_sh[39:0];
    end
  end

  // acceleration, 24 fraction bits, saturated to 48 bits
  always_comb begin
    a_sh = acc_r >>> 8;
    if (!a_sh[80] && (|a_sh[79:47])) begin
      accel_nxt = {1'b0, {47{1'b1}}};
    end else if (a_sh[80] && !(&a_sh[79:47])) begin
      accel_nxt = {1'b1, {47{1'b0}}};
    end else begin
      accel_nxt = a_sh[47:0];
    end
  end

  always_comb begin
    t_sh = acc_r >>> 32;
    vsum = {{18{vel_r[31]}}, vel_r} + t_sh[49:0];
    vlim = {19'd0, max_velocity};
    priority if (vsum > vlim) begin
      vel_nxt = vlim[31:0];
    end else if (vsum < -vlim) begin
      vel_nxt = -vlim[31:0];
    end else begin
      vel_nxt = vsum[31:0];
    end
  end

  always_comb begin
    x_sh = prod_r >>> 32;
    xsum = {{4{ofs_r[31]}}, ofs_r} + x_sh[35:0];
    xlim = {5'd0, max_offset};
    priority if (xsum > xlim) begin
      ofs_nxt = xlim[31:0];
    end else if (xsum < -xlim) begin
      ofs_nxt = -xlim[31:0];
    end else begin
      ofs_nxt = xsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      vel_r  <= '0;
      ofs_r  <= '0;
    end else begin
      if (ctl.tare) begin
        bias_r <= force_in;
      end
      case (ctl.op)
        af3_pkg::OP_V:   vel_r <= vel_nxt;
        af3_pkg::OP_CLR: vel_r <= '0;
        af3_pkg::OP_XA:  ofs_r <= ofs_nxt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    if (ctl.load) begin
      samp_r <= force_in;
    end
    case (ctl.op)
      af3_pkg::OP_SQR: frc_r   <= frc_c;
      af3_pkg::OP_KX:  acc_r   <= net_base - prod_ext;
      af3_pkg::OP_NET: acc_r   <= acc_r - prod_ext;
      af3_pkg::OP_N16: n16_r   <= n16_nxt;
      af3_pkg::OP_ML:  acc_r   <= prod_ext <<< 16;
      af3_pkg::OP_AS:  acc_r   <= acc_r + prod_ext;
      af3_pkg::OP_ACC: accel_r <= accel_nxt;
      af3_pkg::OP_TL:  acc_r   <= prod_ext <<< 24;
      af3_pkg::OP_TS:  acc_r   <= acc_r + prod_ext;
      default: ;
    endcase
  end

  assign force_sq = prod_r[af3_pkg::SQ_W-1:0];
  assign force_nz = |frc_r;
  assign velocity = vel_r;
  assign offset   = ofs_r;

endmodule

`default_nettype wire

[hw/rtl/af3_merge.sv]
// combines the lane squares into the deadband and admit decision
`default_nettype none

module af3_merge (
  input  wire logic                                            clk,
  input  wire logic                                            rst_n,
  input  wire af3_pkg::lane_ctl_t                              ctl,
  input  wire logic [af3_pkg::AXES-1:0][af3_pkg::SQ_W-1:0]     force_sq,
  input  wire logic [af3_pkg::AXES-1:0]                        force_nz,
  input  wire logic [af3_pkg::DB_W-1:0]                        force_deadband,
  output logic                                                 admitted
);

  logic [af3_pkg::DBSQ_W-1:0]  db_sq_r;
  logic [af3_pkg::SQSUM_W-1:0] sq_sum;
  logic                        below;
  logic                        admit_r;

  assign sq_sum = {2'd0, force_sq[0]} + {2'd0, force_sq[1]} + {2'd0, force_sq[2]};
  assign below  = ctl.measured && (sq_sum < {4'd0, db_sq_r});

  // deadband squared, registered so that it tracks the deadband register
  always_ff @(posedge clk) begin
    db_sq_r <= {19'd0, force_deadband} * {19'd0, force_deadband};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      admit_r <= 1'b0;
    end else if (ctl.load) begin
      admit_r <= 1'b0;
    end else if (ctl.op == af3_pkg::OP_SUM) begin
      admit_r <= !below && (|force_nz);
    end
  end

  assign admitted = admit_r;

endmodule

`default_nettype wire

[hw/rtl/af3_ctrl.sv]
// step sequencer shared by the three lanes
`default_nettype none

module af3_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_command,
  input  wire logic               admitted,
  input  wire logic               out_free,
  output logic                    in_ready,
  output af3_pkg::lane_ctl_t      ctl,
  output logic                    out_load
);

  af3_pkg::state_t state_r;
  af3_pkg::state_t state_nxt;
  logic            measured_r;
  logic            accept;

  assign accept = (state_r == af3_pkg::ST_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      af3_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_command == af3_pkg::CMD_MEASURED) || (in_command == af3_pkg::CMD_DIRECT)) begin
            state_nxt = af3_pkg::ST_SQR;
          end else begin
            state_nxt = af3_pkg::ST_OUT;
          end
        end
      end
      af3_pkg::ST_SQR: state_nxt = af3_pkg::ST_SUM;
      af3_pkg::ST_SUM: state_nxt = af3_pkg::ST_CHK;
      af3_pkg::ST_CHK: state_nxt = admitted ? af3_pkg::ST_DV : af3_pkg::ST_OUT;
      af3_pkg::ST_DV:  state_nxt = af3_pkg::ST_KX;
      af3_pkg::ST_KX:  state_nxt = af3_pkg::ST_NET;
      af3_pkg::ST_NET: state_nxt = af3_pkg::ST_N16;
      af3_pkg::ST_N16: state_nxt = af3_pkg::ST_MH;
      af3_pkg::ST_MH:  state_nxt = af3_pkg::ST_ML;
      af3_pkg::ST_ML:  state_nxt = af3_pkg::ST_AS;
      af3_pkg::ST_AS:  state_nxt = af3_pkg::ST_ACC;
      af3_pkg::ST_ACC: state_nxt = af3_pkg::ST_TH;
      af3_pkg::ST_TH:  state_nxt = af3_pkg::ST_TL;
      af3_pkg::ST_TL:  state_nxt = af3_pkg::ST_TS;
      af3_pkg::ST_TS:  state_nxt = af3_pkg::ST_V;
      af3_pkg::ST_V:   state_nxt = af3_pkg::ST_XM;
      af3_pkg::ST_XM:  state_nxt = af3_pkg::ST_XA;
      af3_pkg::ST_XA:  state_nxt = af3_pkg::ST_OUT;
      af3_pkg::ST_OUT: state_nxt = out_free ? af3_pkg::ST_IDLE : af3_pkg::ST_OUT;
      default:         state_nxt = af3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == af3_pkg::ST_IDLE);
    out_load     = (state_r == af3_pkg::ST_OUT) && out_free;
    ctl.load     = accept;
    ctl.tare     = accept && (in_command == af3_pkg::CMD_TARE);
    ctl.measured = measured_r;
    unique case (state_r)
      af3_pkg::ST_SQR: ctl.op = af3_pkg::OP_SQR;
      af3_pkg::ST_SUM: ctl.op = af3_pkg::OP_SUM;
      af3_pkg::ST_CHK: ctl.op = admitted ? af3_pkg::OP_NONE : af3_pkg::OP_CLR;
      af3_pkg::ST_DV:  ctl.op = af3_pkg::OP_DV;
      af3_pkg::ST_KX:  ctl.op = af3_pkg::OP_KX;
      af3_pkg::ST_NET: ctl.op = af3_pkg::OP_NET;
      af3_pkg::ST_N16: ctl.op = af3_pkg::OP_N16;
      af3_pkg::ST_MH:  ctl.op = af3_pkg::OP_MH;
      af3_pkg::ST_ML:  ctl.op = af3_pkg::OP_ML;
      af3_pkg::ST_AS:  ctl.op = af3_pkg::OP_AS;
      af3_pkg::ST_ACC: ctl.op = af3_pkg::OP_ACC;
      af3_pkg::ST_TH:  ctl.op = af3_pkg::OP_TH;
      af3_pkg::ST_TL:  ctl.op = af3_pkg::OP_TL;
      af3_pkg::ST_TS:  ctl.op = af3_pkg::OP_TS;
      af3_pkg::ST_V:   ctl.op = af3_pkg::OP_V;
      af3_pkg::ST_XM:  ctl.op = af3_pkg::OP_XM;
      af3_pkg::ST_XA:  ctl.op = af3_pkg::OP_XA;
      default:         ctl.op = af3_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= af3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      measured_r <= (in_command == af3_pkg::CMD_MEASURED);
    end
  end

endmodule

`default_nettype wire

[tb/sv/af3_checker.sv]
// checker for the three-axis admittance filter: mirrors the registers, predicts and compares results
module af3_checker
  import af3_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 in_command,
  input  logic signed [FORCE_W-1:0]  in_force_x,
  input  logic signed [FORCE_W-1:0]  in_force_y,
  input  logic signed [FORCE_W-1:0]  in_force_z,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [STATE_W-1:0]  out_offset_x,
  input  logic signed [STATE_W-1:0]  out_offset_y,
  input  logic signed [STATE_W-1:0]  out_offset_z,
  input  logic signed [STATE_W-1:0]  out_velocity_x,
  input  logic signed [STATE_W-1:0]  out_velocity_y,
  input  logic signed [STATE_W-1:0]  out_velocity_z,
  input  logic                       out_force_admitted,
  output int                         mismatches,
  output int                         pending,
  output int                         results_checked,
  output int                         admitted_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint N16_MAX   = (64'sd1 <<< (N16_W - 1)) - 1;
  localparam longint N16_MIN   = -(64'sd1 <<< (N16_W - 1));
  localparam longint ACCEL_MAX = (64'sd1 <<< (ACCEL_W - 1)) - 1;
  localparam longint ACCEL_MIN = -(64'sd1 <<< (ACCEL_W - 1));

  typedef struct packed {
    logic [AXES-1:0][STATE_W-1:0] offset;
    logic [AXES-1:0][STATE_W-1:0] velocity;
    logic                         admitted;
  } filter_state_t;

  filter_state_t expected_q[$];

  // register mirror
  logic [GAIN_W-1:0] inv_mass_r, damping_r, stiffness_r;
  logic [DT_W-1:0]   timestep_r;
  logic [DB_W-1:0]   deadband_r;
  logic [LIM_W-1:0]  vmax_r, xmax_r;

  longint bias_st [AXES];
  longint vel_st  [AXES];
  longint ofs_st  [AXES];

  string axis_name [AXES] = '{"x", "y", "z"};

  function automatic longint clamp_to(longint val, longint lo, longint hi);
    if (val < lo) return lo;
    if (val > hi) return hi;
    return val;
  endfunction

  // floor(a * dt / 2^32), exact
  function automatic longint times_dt(longint a);
    logic signed [95:0] wide_a, wide_dt, prod;
    wide_a  = a;
    wide_dt = {64'd0, timestep_r};
    prod    = wide_a * wide_dt;
    return longint'(prod >>> 32);
  endfunction

  // one explicit euler step of one axis
  function automatic void advance_axis(int a, longint push);
    longint net, n16, accel, vlim, xlim;
    vlim  = longint'(vmax_r);
    xlim  = longint'(xmax_r);
    net   = push * 64'sd16777216 - longint'(damping_r) * vel_st[a]
            - longint'(stiffness_r) * ofs_st[a];
    n16   = clamp_to(net >>> 16, N16_MIN, N16_MAX);
    accel = clamp_to((n16 * longint'(inv_mass_r)) >>> 8, ACCEL_MIN, ACCEL_MAX);
    vel_st[a] = clamp_to(vel_st[a] + times_dt(accel), -vlim, vlim);
    ofs_st[a] = clamp_to(ofs_st[a] + times_dt(vel_st[a]), -xlim, xlim);
  endfunction

  function automatic filter_state_t predict_step(logic [1:0] cmd, longint sx, longint sy,
                                                 longint sz);
    longint        reading [AXES];
    longint        push    [AXES];
    longint        mag_sq;
    logic          moved;
    filter_state_t res;
    reading = '{sx, sy, sz};
    moved   = 1'b0;
    mag_sq  = 0;
    if (cmd == CMD_TARE) begin
      for (int a = 0; a < AXES; a++) bias_st[a] = reading[a];
    end else if (cmd == CMD_MEASURED || cmd == CMD_DIRECT) begin
      for (int a = 0; a < AXES; a++) begin
        push[a] = (cmd == CMD_MEASURED) ? bias_st[a] - reading[a] : reading[a];
        mag_sq += push[a] * push[a];
      end
      // deadband only applies to the measured path
      if (cmd == CMD_MEASURED && mag_sq < longint'(deadband_r) * longint'(deadband_r))
        for (int a = 0; a < AXES; a++) push[a] = 0;
      if (push[0] == 0 && push[1] == 0 && push[2] == 0) begin
        for (int a = 0; a < AXES; a++) vel_st[a] = 0;
      end else begin
        for (int a = 0; a < AXES; a++) advance_axis(a, push[a]);
        moved = 1'b1;
      end
    end
    for (int a = 0; a < AXES; a++) begin
      res.offset[a]   = STATE_W'(ofs_st[a]);
      res.velocity[a] = STATE_W'(vel_st[a]);
    end
    res.admitted = moved;
    return res;
  endfunction

  task automatic note_mismatch(string what, longint want_v, longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in result %0d, %s: expected %0d, got %0d",
               results_checked, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    filter_state_t got, want;
    if (!rst_n) begin
      inv_mass_r  = INV_MASS_RST;
      damping_r   = DAMPING_RST;
      stiffness_r = STIFFNESS_RST;
      timestep_r  = TIMESTEP_RST;
      deadband_r  = DEADBAND_RST;
      vmax_r      = MAX_VEL_RST;
      xmax_r      = MAX_OFS_RST;
      for (int a = 0; a < AXES; a++) begin
        bias_st[a] = 0;
        vel_st[a]  = 0;
        ofs_st[a]  = 0;
      end
      expected_q.delete();
      mismatches      = 0;
      results_checked = 0;
      admitted_seen   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_MASS:  inv_mass_r  = cfg_wdata[GAIN_W-1:0];
          CFG_DAMPING:   damping_r   = cfg_wdata[GAIN_W-1:0];
          CFG_STIFFNESS: stiffness_r = cfg_wdata[GAIN_W-1:0];
          CFG_TIMESTEP:  timestep_r  = cfg_wdata[DT_W-1:0];
          CFG_DEADBAND:  deadband_r  = cfg_wdata[DB_W-1:0];
          CFG_MAX_VEL:   vmax_r      = cfg_wdata[LIM_W-1:0];
          CFG_MAX_OFS:   xmax_r      = cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting so a result leaving on the same edge meets its own request
      if (out_valid && out_ready) begin
        got.offset   = {out_offset_z, out_offset_y, out_offset_x};
        got.velocity = {out_velocity_z, out_velocity_y, out_velocity_x};
        got.admitted = out_force_admitted;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no request outstanding: offset %0d %0d %0d",
                     out_offset_x, out_offset_y, out_offset_z);
        end else begin
          want = expected_q.pop_front();
          for (int a = 0; a < AXES; a++) begin
            if (got.offset[a] !== want.offset[a])
              note_mismatch({"offset_", axis_name[a]}, longint'($signed(want.offset[a])),
                            longint'($signed(got.offset[a])));
            if (got.velocity[a] !== want.velocity[a])
              note_mismatch({"velocity_", axis_name[a]}, longint'($signed(want.velocity[a])),
                            longint'($signed(got.velocity[a])));
          end
          if (got.admitted !== want.admitted)
            note_mismatch("force_admitted", longint'(want.admitted), longint'(got.admitted));
          if (want.admitted) admitted_seen++;
          results_checked++;
        end
      end
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(),
                          predict_step(in_command, longint'(in_force_x),
                                       longint'(in_force_y), longint'(in_force_z)));
    end
    pending = expected_q.size();
  end

endmodule

[tb/sv/tb_admittance_filter_3axis.sv]
// testbench top of the three-axis admittance filter: clock, reset, stimulus and verdict
module tb_admittance_filter_3axis;
  timeunit 1ns;
  timeprecision 1ps;
  import af3_pkg::*;

  // the block leaves command code three unused; it must be ignored
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int NUM_REGS           = int'(CFG_MAX_OFS) + 1;
  localparam int NUM_SETTINGS       = 8;
  localparam int RANDOM_PER_SETTING = 192;
  localparam int DRAIN_CYCLES       = 30;   // outlasts a moving step
  localparam int LONG_HOLD          = 200;
  localparam int TIMEOUT_NS         = 5_000_000;

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  // widest legal value of each register, by register index
  localparam logic [CFG_DATA_W-1:0] REG_MAX [NUM_REGS] = '{
    32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF,
    32'h7_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF
  };

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 in_command;
  logic signed [FORCE_W-1:0]  in_force_x;
  logic signed [FORCE_W-1:0]  in_force_y;
  logic signed [FORCE_W-1:0]  in_force_z;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [STATE_W-1:0]  out_offset_x;
  logic signed [STATE_W-1:0]  out_offset_y;
  logic signed [STATE_W-1:0]  out_offset_z;
  logic signed [STATE_W-1:0]  out_velocity_x;
  logic signed [STATE_W-1:0]  out_velocity_y;
  logic signed [STATE_W-1:0]  out_velocity_z;
  logic                       out_force_admitted;

  int mismatches;
  int pending;
  int results_checked;
  int admitted_seen;

  // stimulus bookkeeping
  logic                      calm;           // both sides add no random gaps while set
  int                        requests_sent;
  logic signed [FORCE_W-1:0] tare_reading [AXES];  // last tared sample, to aim near the bias

  admittance_filter_3axis dut (.*);

  af3_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request: random gap unless calm, then hold valid and payload until the block takes it
  task automatic send_request(logic [1:0] cmd, logic signed [FORCE_W-1:0] fx,
                              logic signed [FORCE_W-1:0] fy, logic signed [FORCE_W-1:0] fz);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_force_x <= fx;
    in_force_y <= fy;
    in_force_z <= fz;
    if (cmd == CMD_TARE) tare_reading = '{fx, fy, fz};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    requests_sent++;
  endtask

  // random request: mostly real force steps, some tares, a few unused codes
  task automatic send_random();
    logic [1:0]                cmd;
    logic signed [FORCE_W-1:0] f [AXES];
    int                        pick, style;
    pick  = $urandom_range(0, 99);
    style = $urandom_range(0, 9);
    if (pick < 44)      cmd = CMD_MEASURED;
    else if (pick < 82) cmd = CMD_DIRECT;
    else if (pick < 96) cmd = CMD_TARE;
    else                cmd = CMD_UNUSED;
    for (int a = 0; a < AXES; a++) begin
      case (style)
        0, 1, 2: f[a] = FORCE_W'($urandom);                                 // any 20 bit value
        3, 4:    f[a] = FORCE_W'(int'($urandom_range(0, 4095)) - 2048);     // around deadband
        5:       f[a] = '0;
        6:       f[a] = $urandom_range(0, 1) ? FORCE_MAX : FORCE_MIN;
        7, 8:    f[a] = FORCE_W'(int'(tare_reading[a]) + int'($urandom_range(0, 1599)) - 800);
        default: f[a] = FORCE_W'(int'($urandom_range(0, 65535)) - 32768);   // up to 128 n
      endcase
    end
    // now and then a single quiet axis
    if ($urandom_range(0, 7) == 0) f[$urandom_range(0, AXES - 1)] = '0;
    send_request(cmd, f[0], f[1], f[2]);
  endtask

  // drop valid and let every outstanding result drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write all seven registers, one per cycle, for the given setting
  task automatic apply_setting(int s);
    logic [CFG_DATA_W-1:0] val [NUM_REGS];
    int                    choice;
    case (s)
      1: begin
        // hand guiding: 1 kg, 20 n s/m, no spring, 10 ms period
        val[CFG_INV_MASS]  = 32'd65536;
        val[CFG_DAMPING]   = 32'd5120;
        val[CFG_STIFFNESS] = 32'd0;
        val[CFG_TIMESTEP]  = 32'd42949673;
        val[CFG_DEADBAND]  = 32'd512;
        val[CFG_MAX_VEL]   = 32'd16777216;
        val[CFG_MAX_OFS]   = 32'd8388608;
      end
      2: begin
        for (int r = 0; r < NUM_REGS; r++) val[r] = REG_MAX[r];
      end
      3: begin
        // zero mass inverse, gains, period, deadband and limits
        for (int r = 0; r < NUM_REGS; r++) val[r] = '0;
      end
      4: begin
        // stiff spring with a short period, offset limit in reach
        val[CFG_INV_MASS]  = 32'd16384;
        val[CFG_DAMPING]   = 32'd10240;
        val[CFG_STIFFNESS] = 32'd102400;
        val[CFG_TIMESTEP]  = 32'd17179869;
        val[CFG_DEADBAND]  = 32'd256;
        val[CFG_MAX_VEL]   = 32'd33554432;
        val[CFG_MAX_OFS]   = 32'd4194304;
      end
      default: begin
        for (int r = 0; r < NUM_REGS; r++) begin
          choice = $urandom_range(0, 3);
          if (choice == 0)      val[r] = (r == int'(CFG_TIMESTEP)) ? 32'd1 : 32'd0;
          else if (choice == 1) val[r] = REG_MAX[r];
          else                  val[r] = $urandom & REG_MAX[r];
        end
      end
    endcase
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_wdata <= val[r];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls per result unless calm, two long holds so the block backs up
  initial begin : receiver
    int stall, taken;
    out_ready = 1'b0;
    taken     = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken == 250 || taken == 900) stall = LONG_HOLD;
      else stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_command    = CMD_MEASURED;
    in_force_x    = '0;
    in_force_y    = '0;
    in_force_z    = '0;
    calm          = 1'b0;
    requests_sent = 0;
    tare_reading  = '{default: '0};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under reset values (deadband 2.5 n)
    send_request(CMD_DIRECT, FORCE_MAX, FORCE_MIN, '0);        // full scale, velocity clamps
    send_request(CMD_DIRECT, '0, '0, '0);                      // zero force clears velocity
    send_request(CMD_DIRECT, 20'sd1, '0, '0);                  // smallest direct force
    send_request(CMD_MEASURED, 20'sd100, -20'sd100, 20'sd100); // well inside deadband
    send_request(CMD_MEASURED, -20'sd640, '0, '0);             // norm exactly on deadband
    send_request(CMD_MEASURED, '0, 20'sd639, '0);              // just under deadband
    send_request(CMD_MEASURED, -20'sd370, -20'sd370, -20'sd370); // over only as a sum
    send_request(CMD_TARE, FORCE_MAX, FORCE_MAX, FORCE_MAX);
    send_request(CMD_MEASURED, FORCE_MAX, FORCE_MAX, FORCE_MAX); // equals bias
    send_request(CMD_MEASURED, FORCE_MIN, FORCE_MAX, FORCE_MIN); // widest positive difference
    send_request(CMD_TARE, FORCE_MIN, FORCE_MIN, FORCE_MIN);
    send_request(CMD_MEASURED, FORCE_MAX, FORCE_MIN, FORCE_MAX); // widest negative difference
    send_request(CMD_UNUSED, 20'sd123, -20'sd456, 20'sd789);
    send_request(CMD_UNUSED, -20'sd1, -20'sd1, -20'sd1);
    send_request(CMD_DIRECT, FORCE_MIN, FORCE_MIN, FORCE_MIN);
    send_request(CMD_TARE, '0, '0, '0);
    send_request(CMD_MEASURED, -20'sd1000, 20'sd2000, -20'sd3000);
    // steady push so the offset walks toward its limit
    repeat (6) send_request(CMD_DIRECT, 20'sd200000, -20'sd200000, 20'sd100);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s > 0) begin
        wait_idle();
        apply_setting(s);
      end
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        // some stretches run back to back on both sides
        if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        send_random();
      end
    end

    wait_idle();
    $display("covered %0d requests over %0d register settings, incl. zero and full scale",
             requests_sent, NUM_SETTINGS);
    $display("%0d results checked, %0d of them moved by a force, %0d field mismatches",
             results_checked, admitted_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/af3_pkg.sv
hw/rtl/af3_lane.sv
hw/rtl/af3_merge.sv
hw/rtl/af3_ctrl.sv
hw/rtl/admittance_filter_3axis.sv
tb/sv/af3_checker.sv
tb/sv/tb_admittance_filter_3axis.sv
